// File: hdl/ple_pkg.sv
// Package for the positional list engine: command and status codes,
// controller-to-datapath command and status structures, default sizes.
// No dependencies.
package ple_pkg;

	localparam int unsigned CAPACITY_DEF   = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_WRITE  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_RD,
		S_UP_WR,
		S_INS_WR,
		S_DN_RD,
		S_DN_WR,
		S_RD_RD,
		S_RD_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_IDX_M1,
		ADDR_IDX_P1,
		ADDR_POS
	} addr_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LOAD_LEN,
		IDX_LOAD_POS,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		LEN_HOLD,
		LEN_INC,
		LEN_DEC,
		LEN_CLR
	} len_op_t;

	typedef enum logic {
		WSEL_VALUE,
		WSEL_RDATA
	} wdata_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_in;
		logic       mem_rd;
		logic       mem_wr;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		idx_op_t    idx_op;
		len_op_t    len_op;
		logic       finish;
		status_t    fin_status;
		logic       fin_rd;
	} ctl_t;

	// Conditions the datapath reports back to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic ins_ok;
		logic pos_ok;
		logic ins_at_end;
		logic rem_at_end;
		logic up_last;
		logic dn_last;
	} dp_status_t;

endpackage

// File: hdl/ple_dp.sv
// Datapath of the positional list engine: command latch, entry memory,
// shift index, list length and result registers.
// Depends on ple_pkg.
module ple_dp #(
	parameter int unsigned CAPACITY   = ple_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         command,
	input  logic [6:0]         position,
	input  logic [31:0]        value,
	input  ple_pkg::ctl_t      ctl,
	output ple_pkg::dp_status_t st,
	output logic               done,
	output logic [1:0]         status,
	output logic [31:0]        read_value,
	output logic [6:0]         count
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = ((LW > 7) ? LW : 7) + 1;

	logic [2:0]            cmd_q;
	logic [6:0]            pos_q;
	logic [31:0]           val_q;
	logic [LW-1:0]         len_q;
	logic [LW-1:0]         len_next;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         addr;
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [DATA_WIDTH-1:0] wdata;
	logic [63:0]           val_ext;
	logic [63:0]           rd_ext;
	logic [CW-1:0]         pos_w;
	logic [CW-1:0]         len_w;
	logic [CW-1:0]         idx_w;
	logic [CW-1:0]         pos_m1;
	logic [CW-1:0]         cnt_w;
	logic                  done_q;
	ple_pkg::status_t      res_status_q;
	logic [31:0]           res_read_q;
	logic [6:0]            res_count_q;

	assign pos_w  = CW'(pos_q);
	assign len_w  = CW'(len_q);
	assign idx_w  = CW'(idx_q);
	assign pos_m1 = pos_w - CW'(1);

	assign st.cmd        = ple_pkg::cmd_t'(cmd_q);
	assign st.empty      = (len_q == '0);
	assign st.full       = (len_w == CW'(CAPACITY));
	assign st.ins_ok     = (pos_w != '0) && (pos_w <= len_w + CW'(1));
	assign st.pos_ok     = (pos_w != '0) && (pos_w <= len_w);
	assign st.ins_at_end = (pos_w == len_w + CW'(1));
	assign st.rem_at_end = (pos_w == len_w);
	assign st.up_last    = (idx_w == pos_w);
	assign st.dn_last    = (idx_w + CW'(2) == len_w);

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= value;
		end
	end

	always_comb begin
		case (ctl.addr_sel)
			ple_pkg::ADDR_IDX:    addr = idx_q;
			ple_pkg::ADDR_IDX_M1: addr = idx_q - AW'(1);
			ple_pkg::ADDR_IDX_P1: addr = idx_q + AW'(1);
			default:              addr = pos_m1[AW-1:0];
		endcase
	end

	// Stored values are the low DATA_WIDTH bits of the command value.
	assign val_ext = 64'(val_q);
	assign wdata   = (ctl.wdata_sel == ple_pkg::WSEL_RDATA) ? rdata_q
	                                                         : val_ext[DATA_WIDTH-1:0];
	assign rd_ext  = 64'(rdata_q);

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.idx_op)
			ple_pkg::IDX_LOAD_LEN: idx_q <= len_q[AW-1:0];
			ple_pkg::IDX_LOAD_POS: idx_q <= pos_m1[AW-1:0];
			ple_pkg::IDX_DEC:      idx_q <= idx_q - AW'(1);
			ple_pkg::IDX_INC:      idx_q <= idx_q + AW'(1);
			default:               idx_q <= idx_q;
		endcase
	end

	always_comb begin
		case (ctl.len_op)
			ple_pkg::LEN_INC: len_next = len_q + LW'(1);
			ple_pkg::LEN_DEC: len_next = len_q - LW'(1);
			ple_pkg::LEN_CLR: len_next = '0;
			default:          len_next = len_q;
		endcase
	end

	assign cnt_w = CW'(len_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			done_q <= 1'b0;
		end else begin
			len_q  <= len_next;
			done_q <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_status_q <= ctl.fin_status;
			res_read_q   <= ctl.fin_rd ? rd_ext[31:0] : 32'd0;
			res_count_q  <= cnt_w[6:0];
		end
	end

	assign done       = done_q;
	assign status     = res_status_q;
	assign read_value = res_read_q;
	assign count      = res_count_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_w <= CW'(CAPACITY))
		else $error("list length exceeds capacity");

	a_fail_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && ctl.fin_status != ple_pkg::ST_OK) |=> (len_q == $past(len_q)))
		else $error("failed command changed the list length");

	a_len_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.finish |=> (len_q == $past(len_q)))
		else $error("list length changed outside a result cycle");

endmodule

// File: hdl/ple_ctrl.sv
// Controller of the positional list engine: sequences the memory shift
// loops and result transfers from the datapath's condition flags.
// Depends on ple_pkg.
module ple_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ple_pkg::dp_status_t st,
	output logic                busy,
	output ple_pkg::ctl_t       ctl
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (start) state_next = ple_pkg::S_DECODE;
			end
			ple_pkg::S_DECODE: begin
				state_next = ple_pkg::S_IDLE;
				unique case (st.cmd)
					ple_pkg::CMD_INSERT: begin
						if (st.ins_ok && !st.full) begin
							state_next = st.ins_at_end ? ple_pkg::S_INS_WR : ple_pkg::S_UP_RD;
						end
					end
					ple_pkg::CMD_REMOVE: begin
						if (!st.empty && st.pos_ok && !st.rem_at_end) begin
							state_next = ple_pkg::S_DN_RD;
						end
					end
					ple_pkg::CMD_READ: begin
						if (!st.empty && st.pos_ok) state_next = ple_pkg::S_RD_RD;
					end
					default: state_next = ple_pkg::S_IDLE;
				endcase
			end
			ple_pkg::S_UP_RD:   state_next = ple_pkg::S_UP_WR;
			ple_pkg::S_UP_WR:   state_next = st.up_last ? ple_pkg::S_INS_WR : ple_pkg::S_UP_RD;
			ple_pkg::S_INS_WR:  state_next = ple_pkg::S_IDLE;
			ple_pkg::S_DN_RD:   state_next = ple_pkg::S_DN_WR;
			ple_pkg::S_DN_WR:   state_next = st.dn_last ? ple_pkg::S_IDLE : ple_pkg::S_DN_RD;
			ple_pkg::S_RD_RD:   state_next = ple_pkg::S_RD_DONE;
			ple_pkg::S_RD_DONE: state_next = ple_pkg::S_IDLE;
			default:            state_next = ple_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.addr_sel   = ple_pkg::ADDR_IDX;
		ctl.wdata_sel  = ple_pkg::WSEL_VALUE;
		ctl.idx_op     = ple_pkg::IDX_HOLD;
		ctl.len_op     = ple_pkg::LEN_HOLD;
		ctl.fin_status = ple_pkg::ST_OK;
		busy           = (state_q != ple_pkg::S_IDLE);
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				ctl.load_in = start;
			end
			ple_pkg::S_DECODE: begin
				unique case (st.cmd)
					ple_pkg::CMD_INSERT: begin
						if (!st.ins_ok) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ple_pkg::ST_BADPOS;
						end else if (st.full) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ple_pkg::ST_FULL;
						end else if (!st.ins_at_end) begin
							ctl.idx_op = ple_pkg::IDX_LOAD_LEN;
						end
					end
					ple_pkg::CMD_REMOVE, ple_pkg::CMD_READ, ple_pkg::CMD_WRITE: begin
						if (st.empty) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ple_pkg::ST_EMPTY;
						end else if (!st.pos_ok) begin
							ctl.finish     = 1'b1;
							ctl.fin_status = ple_pkg::ST_BADPOS;
						end else if (st.cmd == ple_pkg::CMD_REMOVE) begin
							if (st.rem_at_end) begin
								ctl.finish = 1'b1;
								ctl.len_op = ple_pkg::LEN_DEC;
							end else begin
								ctl.idx_op = ple_pkg::IDX_LOAD_POS;
							end
						end else if (st.cmd == ple_pkg::CMD_WRITE) begin
							ctl.mem_wr   = 1'b1;
							ctl.addr_sel = ple_pkg::ADDR_POS;
							ctl.finish   = 1'b1;
						end
					end
					ple_pkg::CMD_CLEAR: begin
						ctl.finish = 1'b1;
						ctl.len_op = ple_pkg::LEN_CLR;
					end
					default: begin
						// Undefined command codes report ok and change nothing.
						ctl.finish = 1'b1;
					end
				endcase
			end
			ple_pkg::S_UP_RD: begin
				ctl.mem_rd   = 1'b1;
				ctl.addr_sel = ple_pkg::ADDR_IDX_M1;
			end
			ple_pkg::S_UP_WR: begin
				ctl.mem_wr    = 1'b1;
				ctl.wdata_sel = ple_pkg::WSEL_RDATA;
				if (!st.up_last) ctl.idx_op = ple_pkg::IDX_DEC;
			end
			ple_pkg::S_INS_WR: begin
				ctl.mem_wr   = 1'b1;
				ctl.addr_sel = ple_pkg::ADDR_POS;
				ctl.len_op   = ple_pkg::LEN_INC;
				ctl.finish   = 1'b1;
			end
			ple_pkg::S_DN_RD: begin
				ctl.mem_rd   = 1'b1;
				ctl.addr_sel = ple_pkg::ADDR_IDX_P1;
			end
			ple_pkg::S_DN_WR: begin
				ctl.mem_wr    = 1'b1;
				ctl.wdata_sel = ple_pkg::WSEL_RDATA;
				if (st.dn_last) begin
					ctl.finish = 1'b1;
					ctl.len_op = ple_pkg::LEN_DEC;
				end else begin
					ctl.idx_op = ple_pkg::IDX_INC;
				end
			end
			ple_pkg::S_RD_RD: begin
				ctl.mem_rd   = 1'b1;
				ctl.addr_sel = ple_pkg::ADDR_POS;
			end
			ple_pkg::S_RD_DONE: begin
				ctl.finish = 1'b1;
				ctl.fin_rd = 1'b1;
			end
			default: begin
				ctl.finish = 1'b0;
			end
		endcase
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ple_pkg::S_DECODE))
		else $error("accepted command did not reach decode");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> (state_q == ple_pkg::S_IDLE))
		else $error("controller did not return to idle after a result");

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.mem_rd && ctl.mem_wr))
		else $error("memory read and write issued in the same cycle");

endmodule

// File: hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl and ple_dp.
//
//  Channel   Handshake              Payload
//  command   start / busy           command, position, value
//  result    done (one-cycle pulse) status, read_value, count
//
// A command is taken on a clock edge with start high and busy low. Entries
// live in a single-port memory, so a shift moves each entry with a read
// state and then a write state. Write, clear, error and tail-remove finish
// in decode; a read reads the entry, then finishes; an insert moves the
// entries from its position on up, then writes; a remove moves the later
// entries down. busy drops as the result is issued, so the next command
// may be taken in the done cycle. Reset empties the list; entry contents are
// left as they are. The receiver cannot stall, so results are never held.
module positional_list_engine_unit #(
	parameter int unsigned CAPACITY   = ple_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [6:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  count
);

	ple_pkg::ctl_t       ctl;
	ple_pkg::dp_status_t st;

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.ctl    (ctl)
	);

	ple_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.position   (position),
		.value      (value),
		.ctl        (ctl),
		.st         (st),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

endmodule
